[hdl/qtpr_pkg.sv]
// Package for the quadtree path raster painter.
// Holds item codes, field widths, defaults and the controller/datapath
// command and status structs. No dependencies.
package qtpr_pkg;

  // Field widths of the item and result ports
  localparam int FUNC_W       = 2;
  localparam int DIGITS_W     = 18;
  localparam int PLEN_W       = 4;
  localparam int ROW_IDX_W    = 9;
  localparam int WORD_IDX_W   = 3;
  localparam int PIXEL_W      = 64;
  localparam int SIDE_LOG2_W  = 4;

  // Defaults
  localparam int MAX_SIDE_LOG2_DEF = 9;
  localparam int MAX_DIGITS        = 9;
  localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RST = 4'd9;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAINT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;         // capture item fields and paint geometry
    logic clear_step;   // write zero at sweep address, advance sweep
    logic paint_step;   // issue read of next painted word, advance
    logic read_issue;   // issue read of the requested word
    logic result_load;  // load the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clear_last;   // sweep is at the last store word
    logic paint_last;   // paint walk is at its last word
  } status_t;

endpackage

[hdl/qtpr_ctrl.sv]
// Controller state machine for the quadtree path raster painter.
// Sequences clear sweeps, paint walks, reads and result delivery.
// Depends on qtpr_pkg.
module qtpr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [qtpr_pkg::FUNC_W-1:0]  in_func_i,
  output logic                         in_stall_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output qtpr_pkg::cmd_t               cmd_o,
  input  qtpr_pkg::status_t            status_i
);
  import qtpr_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StPaint = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StResp  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       resp_q, resp_d;       // clear sweep owes a result
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    resp_d  = resp_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (in_func_i)
            FUNC_CLEAR: begin
              state_d = StClear;
              resp_d  = 1'b1;
            end
            FUNC_PAINT:  state_d = StPaint;
            FUNC_READ:   state_d = StRead;
            FUNC_UNUSED: state_d = StResp;
            default:     state_d = StResp;
          endcase
        end
      end
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = resp_q ? StResp : StIdle;
          resp_d  = 1'b0;
        end
      end
      StPaint: begin
        cmd_o.paint_step = 1'b1;
        if (status_i.paint_last) state_d = StDrain;
      end
      StDrain: state_d = StResp;
      StRead: begin
        cmd_o.read_issue = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        if (slot_free) begin
          cmd_o.result_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  // Reset starts with a clear sweep that owes no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      resp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      resp_q      <= resp_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/qtpr_datapath.sv]
// Datapath for the quadtree path raster painter: pixel store memory,
// paint geometry, sweep and walk counters, read-modify-write and result.
// Depends on qtpr_pkg.
module qtpr_datapath #(
  parameter int MAX_SIDE_LOG2 = qtpr_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qtpr_pkg::cmd_t                    cmd_i,
  output qtpr_pkg::status_t                 status_o,
  input  logic [qtpr_pkg::SIDE_LOG2_W-1:0]  side_log2_i,
  input  logic [qtpr_pkg::FUNC_W-1:0]       func_i,
  input  logic [qtpr_pkg::DIGITS_W-1:0]     path_digits_i,
  input  logic [qtpr_pkg::PLEN_W-1:0]       path_length_i,
  input  logic [qtpr_pkg::ROW_IDX_W-1:0]    row_index_i,
  input  logic [qtpr_pkg::WORD_IDX_W-1:0]   word_index_i,
  output logic [qtpr_pkg::PIXEL_W-1:0]      pixel_word_o,
  output logic                              is_read_data_o
);
  import qtpr_pkg::*;

  localparam int M          = MAX_SIDE_LOG2;
  localparam int WordShift  = (M > 6) ? M - 6 : 0;
  localparam int WordCntW   = (WordShift > 0) ? WordShift : 1;
  localparam int WordsPerRow = 1 << WordShift;
  localparam int AddrW      = M + WordShift;
  localparam int Depth      = 1 << AddrW;
  localparam int XW         = M + 1;   // holds a column count up to the side
  localparam int BW         = XW + 7;  // room for word base plus 64

  // Pixel store
  logic [PIXEL_W-1:0] mem [Depth];
  logic [PIXEL_W-1:0] rdata_q;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [PIXEL_W-1:0] wdata;
  logic               re;
  logic [AddrW-1:0]   raddr;

  // Captured item
  logic [FUNC_W-1:0]   func_q;
  logic [AddrW-1:0]    rd_addr_q;
  logic                in_range_q;
  logic [M-1:0]        x0_q;
  logic [XW-1:0]       xend_q;
  logic [M-1:0]        row_q, row_last_q;
  logic [WordCntW-1:0] wcnt_q, wfirst_q, wlast_q;

  // Sweep and write-back pipeline
  logic [AddrW-1:0]    sweep_q;
  logic                wv_p_q;
  logic [AddrW-1:0]    addr_p_q;
  logic [PIXEL_W-1:0]  mask_p_q;

  // Output register
  logic [PIXEL_W-1:0]  pixel_q;
  logic                is_read_q;

  // Geometry of the painted square
  logic [SIDE_LOG2_W-1:0] lg, n;
  logic [M-1:0]           x0, y0;
  logic [XW-1:0]          size, xend;
  logic [M-1:0]           y_last;
  logic [WordCntW-1:0]    w_first, w_last;
  int                     lvl;

  always_comb begin
    lvl = 0;
    lg = (side_log2_i > SIDE_LOG2_W'(M)) ? SIDE_LOG2_W'(M) : side_log2_i;
    n  = path_length_i;
    if (n > lg) n = lg;
    if (n > SIDE_LOG2_W'(MAX_DIGITS)) n = SIDE_LOG2_W'(MAX_DIGITS);
    x0 = '0;
    y0 = '0;
    // coordinate bit j takes the digit of level lg-1-j
    for (int j = 0; j < M; j++) begin
      lvl = int'(lg) - 1 - j;
      if (lvl >= 0 && lvl < int'(n)) begin
        x0[j] = path_digits_i[2*lvl];
        y0[j] = path_digits_i[2*lvl+1];
      end
    end
    size    = XW'(1) << (lg - n);
    xend    = XW'(x0) + size;
    y_last  = y0 + M'(size - XW'(1));
    w_first = WordCntW'(x0 >> 6);
    w_last  = WordCntW'((xend - XW'(1)) >> 6);
  end

  // Mask of the current word in the paint walk
  logic [BW-1:0]      base, x0_e, xend_e, hi_rel;
  logic [5:0]         lo_off;
  logic [6:0]         hi_cnt;
  logic [PIXEL_W-1:0] mask;
  logic [AddrW-1:0]   paint_addr;

  always_comb begin
    base   = BW'(wcnt_q) << 6;
    x0_e   = BW'(x0_q);
    xend_e = BW'(xend_q);
    lo_off = (x0_e > base) ? 6'(x0_e - base) : 6'd0;
    hi_rel = xend_e - base;
    hi_cnt = (hi_rel > BW'(64)) ? 7'd64 : 7'(hi_rel);
    mask   = ({PIXEL_W{1'b1}} << lo_off) & ({PIXEL_W{1'b1}} >> (7'd64 - hi_cnt));
    paint_addr = (AddrW'(row_q) << WordShift) | AddrW'(wcnt_q);
  end

  assign status_o.clear_last = &sweep_q;
  assign status_o.paint_last = (wcnt_q == wlast_q) && (row_q == row_last_q);

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = addr_p_q;
    wdata = rdata_q | mask_p_q;
    if (cmd_i.clear_step) begin
      we    = 1'b1;
      waddr = sweep_q;
      wdata = '0;
    end else if (wv_p_q) begin
      we = 1'b1;
    end
    re    = cmd_i.paint_step || cmd_i.read_issue;
    raddr = cmd_i.paint_step ? paint_addr : rd_addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Item capture and paint walk counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= func_i;
      rd_addr_q  <= (AddrW'(M'(row_index_i)) << WordShift) |
                    AddrW'(WordCntW'(word_index_i));
      in_range_q <= (int'(row_index_i) < (1 << M)) && (int'(word_index_i) < WordsPerRow);
      x0_q       <= x0;
      xend_q     <= xend;
      row_q      <= y0;
      row_last_q <= y_last;
      wfirst_q   <= w_first;
      wlast_q    <= w_last;
      wcnt_q     <= w_first;
    end else if (cmd_i.paint_step) begin
      if (wcnt_q == wlast_q) begin
        wcnt_q <= wfirst_q;
        row_q  <= row_q + M'(1);
      end else begin
        wcnt_q <= wcnt_q + WordCntW'(1);
      end
    end
    // write-back stage of the read-modify-write
    addr_p_q <= paint_addr;
    mask_p_q <= mask;
    if (cmd_i.result_load) begin
      is_read_q <= (func_q == FUNC_READ);
      pixel_q   <= (func_q == FUNC_READ && in_range_q) ? rdata_q : '0;
    end
  end

  // Control state: sweep counter and write-back valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      wv_p_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_step) sweep_q <= sweep_q + AddrW'(1);
      wv_p_q <= cmd_i.paint_step;
    end
  end

  assign pixel_word_o   = pixel_q;
  assign is_read_data_o = is_read_q;

endmodule

[hdl/quadtree_path_raster_painter.sv]
// Quadtree path raster painter. A clear writes zero to every store word, one
// per cycle (2^(2*M-6) words, 4096 at M=9); a paint walks its rows and words.
// One item at a time; paint and clear walk a memory with a read and a write port.
// Reset: asynchronous, clears control state and runs a clear pass over all
// store words with input stalled; side_log2 resets to 9.
module quadtree_path_raster_painter #(
  parameter int MAX_SIDE_LOG2 = qtpr_pkg::MAX_SIDE_LOG2_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qtpr_pkg::SIDE_LOG2_W-1:0]  cfg_data_i,
  // item channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [qtpr_pkg::FUNC_W-1:0]       func_i,
  input  logic [qtpr_pkg::DIGITS_W-1:0]     path_digits_i,
  input  logic [qtpr_pkg::PLEN_W-1:0]       path_length_i,
  input  logic [qtpr_pkg::ROW_IDX_W-1:0]    row_index_i,
  input  logic [qtpr_pkg::WORD_IDX_W-1:0]   word_index_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qtpr_pkg::PIXEL_W-1:0]      pixel_word_o,
  output logic                              is_read_data_o
);
  import qtpr_pkg::*;

  logic [SIDE_LOG2_W-1:0] side_log2_q;
  cmd_t                   cmd;
  status_t                status;

  // Side register, written on a config transaction
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_log2_q <= SIDE_LOG2_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      side_log2_q <= cfg_data_i;
    end
  end

  qtpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (func_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  qtpr_datapath #(
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .side_log2_i    (side_log2_q),
    .func_i         (func_i),
    .path_digits_i  (path_digits_i),
    .path_length_i  (path_length_i),
    .row_index_i    (row_index_i),
    .word_index_i   (word_index_i),
    .pixel_word_o   (pixel_word_o),
    .is_read_data_o (is_read_data_o)
  );

`ifndef SYNTH
  // an accepted item always keeps the block stalled in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item still in flight");

  // non-read results carry an all-zero word
  a_zero_non_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_read_data_o) |-> (pixel_word_o == '0))
    else $error("non-read result with nonzero pixel word");

  // a result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.result_load)
    else $error("result register overwritten while stalled");
`endif

endmodule

[tb/quadtree_path_raster_painter_checker.sv]
`timescale 1ns / 1ps
// Result checker for quadtree_path_raster_painter: watches the configuration,
// item and result channels, keeps its own raster copy and compares results.
// Depends on qtpr_pkg.
module quadtree_path_raster_painter_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [qtpr_pkg::SIDE_LOG2_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [qtpr_pkg::FUNC_W-1:0]        func_i,
  input  logic [qtpr_pkg::DIGITS_W-1:0]      path_digits_i,
  input  logic [qtpr_pkg::PLEN_W-1:0]        path_length_i,
  input  logic [qtpr_pkg::ROW_IDX_W-1:0]     row_index_i,
  input  logic [qtpr_pkg::WORD_IDX_W-1:0]    word_index_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [qtpr_pkg::PIXEL_W-1:0]       pixel_word_i,
  input  logic                               is_read_data_i,
  output int unsigned                        pending_o,
  output int unsigned                        fail_count_o
);
  import qtpr_pkg::*;

  localparam int unsigned ROWS  = 1 << MAX_SIDE_LOG2_DEF;
  localparam int unsigned WORDS = (ROWS + 63) / 64;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic               is_read_data;
  } pixel_result_t;

  // Raster copy, side register copy and results still owed by the block
  logic [PIXEL_W-1:0]     raster_bits [ROWS][WORDS];
  logic [SIDE_LOG2_W-1:0] side_log2_q;
  pixel_result_t          owed_results [$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                 input logic [PIXEL_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic void wipe_raster();
    for (int unsigned r = 0; r < ROWS; r++)
      for (int unsigned w = 0; w < WORDS; w++)
        raster_bits[r][w] = '0;
  endfunction

  // Walk the quadrant digits down to a square, then set it word by word
  function automatic void paint_square(input logic [DIGITS_W-1:0] digits,
                                       input logic [PLEN_W-1:0] len);
    int unsigned lg, side, n, x0, y0, sz, half, base, lo, hi, cnt, i, y, w;
    logic [1:0]         quad;
    logic [PIXEL_W-1:0] mask;
    lg   = (side_log2_q > MAX_SIDE_LOG2_DEF) ? MAX_SIDE_LOG2_DEF : side_log2_q;
    side = 1 << lg;
    n    = len;
    if (n > lg) n = lg;
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    x0 = 0;
    y0 = 0;
    for (i = 0; i < n; i++) begin
      quad = digits[2*i +: 2];
      half = side >> (i + 1);
      if (quad[0]) x0 += half;
      if (quad[1]) y0 += half;
    end
    sz = side >> n;
    for (y = y0; y < y0 + sz && y < ROWS; y++) begin
      for (w = 0; w < WORDS; w++) begin
        base = w * 64;
        lo   = (x0 > base) ? x0 : base;
        hi   = (x0 + sz < base + 64) ? x0 + sz : base + 64;
        if (lo < hi) begin
          cnt  = hi - lo;
          mask = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1) << (lo - base);
          raster_bits[y][w] |= mask;
        end
      end
    end
  endfunction

  // Sample every channel at the rising edge; results are checked before new
  // items are predicted so a same-cycle pair stays in order
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_result_t want, got;
    if (!rst_ni) begin
      wipe_raster();
      side_log2_q = SIDE_LOG2_RST;
      owed_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) side_log2_q = cfg_data_i;

      if (out_valid_i && !out_stall_i) begin
        got.pixel_word   = pixel_word_i;
        got.is_read_data = is_read_data_i;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", got.pixel_word, '0);
        end else begin
          want = owed_results.pop_front();
          if (got.pixel_word !== want.pixel_word)
            report_mismatch("pixel_word", got.pixel_word, want.pixel_word);
          if (got.is_read_data !== want.is_read_data)
            report_mismatch("is_read_data", 64'(got.is_read_data), 64'(want.is_read_data));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        want.pixel_word   = '0;
        want.is_read_data = 1'b0;
        case (func_i)
          FUNC_CLEAR: wipe_raster();
          FUNC_PAINT: paint_square(path_digits_i, path_length_i);
          FUNC_READ: begin
            // rows or words past the physical store read as zero
            if (row_index_i < ROWS && word_index_i < WORDS)
              want.pixel_word = raster_bits[row_index_i][word_index_i];
            want.is_read_data = 1'b1;
          end
          default: ;
        endcase
        // append at the tail of the owed queue
        owed_results = {owed_results, want};
      end

      pending_o = owed_results.size();
    end
  end

endmodule

[tb/quadtree_path_raster_painter_test.sv]
`timescale 1ns / 1ps
// Testbench top for quadtree_path_raster_painter: clock, reset, directed and
// random item stimulus, side register writes, result back-pressure, watchdog
// and verdict. Depends on qtpr_pkg, the block and the result checker.
module quadtree_path_raster_painter_test;
  import qtpr_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int unsigned QUIET_LIMIT  = 30000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SEGMENTS     = 7;
  localparam int unsigned SEG_ITEMS    = 16;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [SIDE_LOG2_W-1:0] cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [FUNC_W-1:0]      func       = FUNC_CLEAR;
  logic [DIGITS_W-1:0]    digits     = '0;
  logic [PLEN_W-1:0]      path_len   = '0;
  logic [ROW_IDX_W-1:0]   row_idx    = '0;
  logic [WORD_IDX_W-1:0]  word_idx   = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [PIXEL_W-1:0]     pixel_word;
  logic                   is_read_data;

  int unsigned pending;
  int unsigned fail_count;

  // Idling percentages, receiver hold-off request, stimulus shaping state
  int unsigned         send_gap_pct   = 0;
  int unsigned         recv_stall_pct = 0;
  logic                hold_req       = 1'b0;
  int unsigned         hold_left      = 0;
  int unsigned         eff_side       = MAX_SIDE_LOG2_DEF;
  logic [DIGITS_W-1:0] last_digits    = '0;
  logic [PLEN_W-1:0]   last_len       = '0;

  always #(HALF_PERIOD) clk = ~clk;

  quadtree_path_raster_painter u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .path_digits_i  (digits),
    .path_length_i  (path_len),
    .row_index_i    (row_idx),
    .word_index_i   (word_idx),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_word_o   (pixel_word),
    .is_read_data_o (is_read_data)
  );

  quadtree_path_raster_painter_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .path_digits_i  (digits),
    .path_length_i  (path_len),
    .row_index_i    (row_idx),
    .word_index_i   (word_idx),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_word_i   (pixel_word),
    .is_read_data_i (is_read_data),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // Result side: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: too many cycles without any transaction ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    @(posedge clk);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  // One item transaction; payload holds while stalled
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DIGITS_W-1:0] dg,
                           input logic [PLEN_W-1:0] len, input logic [ROW_IDX_W-1:0] row,
                           input logic [WORD_IDX_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    digits   <= dg;
    path_len <= len;
    row_idx  <= row;
    word_idx <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // Side register write, only once every owed result has come back
  task automatic write_side(input logic [SIDE_LOG2_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    eff_side = (value > MAX_SIDE_LOG2_DEF) ? MAX_SIDE_LOG2_DEF : value;
  endtask

  // Random item: mostly paints and reads, reads often aimed at the last square
  task automatic send_random_item();
    int unsigned         pick, side, n, i, half, col, top, sz;
    logic [1:0]          quad;
    logic [DIGITS_W-1:0] dg;
    logic [PLEN_W-1:0]   len;
    logic [ROW_IDX_W-1:0] row;
    logic [WORD_IDX_W-1:0] word;
    side = 1 << eff_side;
    dg   = DIGITS_W'($urandom);
    // small paths at large sides are slow, so deep paths dominate
    len  = ($urandom_range(0, 3) == 0) ? PLEN_W'($urandom_range(0, 15))
                                       : PLEN_W'($urandom_range(4, 15));
    row  = ROW_IDX_W'($urandom);
    word = WORD_IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_item(FUNC_CLEAR, dg, len, row, word);
    end else if (pick < 9) begin
      send_item(FUNC_UNUSED, dg, len, row, word);
    end else if (pick < 50) begin
      last_digits = dg;
      last_len    = len;
      send_item(FUNC_PAINT, dg, len, row, word);
    end else begin
      if (pick < 80) begin
        n = last_len;
        if (n > eff_side) n = eff_side;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        col = 0;
        top = 0;
        for (i = 0; i < n; i++) begin
          quad = last_digits[2*i +: 2];
          half = side >> (i + 1);
          if (quad[0]) col += half;
          if (quad[1]) top += half;
        end
        sz   = side >> n;
        row  = ROW_IDX_W'(top + $urandom_range(0, sz - 1));
        word = WORD_IDX_W'((col + $urandom_range(0, sz - 1)) / 64);
      end else if (pick < 92) begin
        row  = ROW_IDX_W'($urandom_range(0, side - 1));
        word = WORD_IDX_W'($urandom_range(0, (side - 1) / 64));
      end
      send_item(FUNC_READ, dg, len, row, word);
    end
  endtask

  initial begin : stimulus
    int unsigned seg, k;
    logic [SIDE_LOG2_W-1:0] side_val;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(31, 51);

    // Directed: corners, long paths, unused code, clears, full paint
    write_side(4'd9);
    send_item(FUNC_READ, '0, '0, 9'd0, 3'd0);
    send_item(FUNC_READ, '0, '0, 9'd511, 3'd7);
    send_item(FUNC_PAINT, '1, 4'd9, '0, '0);
    send_item(FUNC_READ, '0, '0, 9'd511, 3'd7);
    send_item(FUNC_PAINT, '1, 4'd15, '0, '0);       // path longer than the side
    send_item(FUNC_PAINT, '0, 4'd9, '0, '0);
    send_item(FUNC_READ, '0, '0, 9'd0, 3'd0);
    send_item(FUNC_PAINT, 18'h00039, 4'd3, '0, '0); // right, bottom-left, bottom-right
    send_item(FUNC_READ, '0, '0, 9'd200, 3'd5);
    send_item(FUNC_UNUSED, '1, '1, '1, '1);
    send_item(FUNC_READ, '0, '0, 9'd200, 3'd4);
    send_item(FUNC_CLEAR, '1, '1, '1, '1);
    send_item(FUNC_READ, '0, '0, 9'd511, 3'd7);
    send_item(FUNC_PAINT, '0, 4'd0, '0, '0);        // whole raster
    send_item(FUNC_READ, '0, '0, 9'd300, 3'd5);
    send_item(FUNC_CLEAR, '0, '0, '0, '0);

    // One-pixel raster, then a side change that must keep the pixel
    write_side(4'd0);
    send_item(FUNC_PAINT, 18'h2AAAA, 4'd5, '0, '0);
    send_item(FUNC_READ, '0, '0, 9'd0, 3'd0);
    send_item(FUNC_READ, '0, '0, 9'd0, 3'd1);
    write_side(4'd15);                             // above the maximum side
    send_item(FUNC_READ, '0, '0, 9'd0, 3'd0);
    send_item(FUNC_PAINT, 18'h00003, 4'd1, '0, '0);
    send_item(FUNC_READ, '0, '0, 9'd256, 3'd4);
    send_item(FUNC_READ, '0, '0, 9'd255, 3'd4);
    write_side(4'd2);
    send_item(FUNC_READ, '0, '0, 9'd100, 3'd6);     // outside the side, inside the store
    send_item(FUNC_PAINT, '1, 4'd4, '0, '0);
    send_item(FUNC_READ, '0, '0, 9'd3, 3'd0);

    // Random segments, each under its own side setting
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) set_idling(51, 31);
      if (seg == 5) set_idling(0, 0);
      case (seg)
        1:       side_val = 4'd15;
        2:       side_val = 4'd1;
        4:       side_val = 4'd0;
        5:       side_val = 4'd9;
        default: side_val = SIDE_LOG2_W'($urandom_range(0, 15));
      endcase
      write_side(side_val);
      if (seg == 5) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      for (k = 0; k < SEG_ITEMS; k++) send_random_item();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/qtpr_pkg.sv
hdl/qtpr_ctrl.sv
hdl/qtpr_datapath.sv
hdl/quadtree_path_raster_painter.sv
tb/quadtree_path_raster_painter_checker.sv
tb/quadtree_path_raster_painter_test.sv
